// ===== hw/rtl/bprle_pkg.sv =====
// Shared types, constants and helper functions for the byte plane RLE decoder.
package bprle_pkg;

  localparam int unsigned MAX_PIXELS   = 16384;
  localparam int unsigned MAX_CHANNELS = 16;
  localparam int unsigned MAX_BYTES    = 4;

  localparam int unsigned PIX_W    = 15;
  localparam int unsigned IDX_W    = 14;
  localparam int unsigned CH_W     = 5;
  localparam int unsigned SB_W     = 3;
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned LANE_W   = 2;
  localparam int unsigned PLANE_W  = 2;
  localparam int unsigned OFF_W    = 20;
  localparam int unsigned STRIDE_W = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_LE       = 2'd3;

  typedef enum logic [1:0] {
    PH_COUNT   = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2,
    PH_SKIP    = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_record;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        value;
    logic [IDX_W-1:0]  pixel_index;
    logic [LEN_W-1:0]  run_length;
    logic [LANE_W-1:0] byte_lane;
    logic [OFF_W-1:0]  byte_offset;
    logic              overrun;
    logic              record_done;
  } out_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_count;
    logic [CH_W-1:0]  channel_count;
    logic [SB_W-1:0]  sample_bytes;
    logic             host_little_endian;
  } cfg_t;

  // One decoded run, before lane and buffer offset are placed.
  typedef struct packed {
    logic [7:0]         value;
    logic [IDX_W-1:0]   pixel_index;
    logic [LEN_W-1:0]   run_length;
    logic [PLANE_W-1:0] plane;
    logic               overrun;
    logic               record_done;
  } run_t;

  function automatic logic [PIX_W-1:0] eff_pixels(input logic [PIX_W-1:0] v);
    logic [PIX_W-1:0] r;
    r = v;
    if (v == '0) r = PIX_W'(1);
    else if (v > PIX_W'(MAX_PIXELS)) r = PIX_W'(MAX_PIXELS);
    return r;
  endfunction

  function automatic logic [CH_W-1:0] eff_channels(input logic [CH_W-1:0] v);
    logic [CH_W-1:0] r;
    r = v;
    if (v == '0) r = CH_W'(1);
    else if (v > CH_W'(MAX_CHANNELS)) r = CH_W'(MAX_CHANNELS);
    return r;
  endfunction

  function automatic logic [SB_W-1:0] eff_bytes(input logic [SB_W-1:0] v);
    logic [SB_W-1:0] r;
    r = v;
    if (v == '0) r = SB_W'(1);
    else if (v > SB_W'(MAX_BYTES)) r = SB_W'(MAX_BYTES);
    return r;
  endfunction

  // sb is already clamped to 1..MAX_BYTES
  function automatic logic [LANE_W-1:0] lane_of(input logic [PLANE_W-1:0] plane,
                                                input logic [SB_W-1:0]    sb,
                                                input logic               le);
    logic [SB_W-1:0] top;
    logic [SB_W-1:0] p;
    top = sb - SB_W'(1);
    p   = SB_W'(plane);
    if (p > top) p = top;
    return le ? LANE_W'(top - p) : LANE_W'(p);
  endfunction

endpackage

// ===== hw/rtl/bprle_parse.sv =====
// Packet parser: count/repeat/literal/skip state machine producing at most one run per data byte.
module bprle_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  bprle_pkg::in_item_t item_i,
  input  bprle_pkg::cfg_t    cfg_i,
  output logic               has_run_o,
  output bprle_pkg::run_t    run_o
);

  bprle_pkg::phase_e                 phase_q, phase_d, phase_c;
  logic [bprle_pkg::LEN_W-1:0]       rr_q, rr_d, rr_c;
  logic [bprle_pkg::PIX_W-1:0]       pos_q, pos_d, pos_c;
  logic [bprle_pkg::PLANE_W-1:0]     plane_q, plane_d, plane_c;
  logic                              fin_q, fin_d, fin_c;

  logic [bprle_pkg::PIX_W-1:0]       pc;
  logic [bprle_pkg::PIX_W-1:0]       left;
  logic [bprle_pkg::SB_W-1:0]        sb;
  logic [bprle_pkg::LEN_W-1:0]       want;
  logic [bprle_pkg::LEN_W-1:0]       more;
  logic [bprle_pkg::LEN_W-1:0]       len;
  logic                              cut;
  logic                              plane_end;
  logic                              last_plane;
  logic [7:0]                        b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bprle_pkg::PH_COUNT;
      rr_q    <= '0;
      pos_q   <= '0;
      plane_q <= '0;
      fin_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      rr_q    <= rr_d;
      pos_q   <= pos_d;
      plane_q <= plane_d;
      fin_q   <= fin_d;
    end
  end

  always_comb begin
    b       = item_i.data_byte;
    phase_c = phase_q;
    rr_c    = rr_q;
    pos_c   = pos_q;
    plane_c = plane_q;
    fin_c   = fin_q;
    if (item_i.start_record) begin
      phase_c = bprle_pkg::PH_COUNT;
      rr_c    = '0;
      pos_c   = '0;
      plane_c = '0;
      fin_c   = 1'b0;
    end

    pc   = bprle_pkg::eff_pixels(cfg_i.pixel_count);
    sb   = bprle_pkg::eff_bytes(cfg_i.sample_bytes);
    left = pc - pos_c;

    want = (phase_c == bprle_pkg::PH_REPEAT) ? rr_c : bprle_pkg::LEN_W'(1);
    if (want == '0) want = bprle_pkg::LEN_W'(1);
    more = (phase_c == bprle_pkg::PH_LITERAL && rr_c > bprle_pkg::LEN_W'(1)) ?
           rr_c - bprle_pkg::LEN_W'(1) : '0;

    if (pos_c >= pc) begin
      len       = bprle_pkg::LEN_W'(1);
      cut       = 1'b1;
      plane_end = 1'b1;
    end else begin
      cut       = bprle_pkg::PIX_W'(want) > left;
      len       = cut ? left[bprle_pkg::LEN_W-1:0] : want;
      plane_end = bprle_pkg::PIX_W'(want) >= left;
      if (plane_end && more != '0) cut = 1'b1;
    end
    last_plane = (bprle_pkg::SB_W'(plane_c) + bprle_pkg::SB_W'(1)) >= sb;

    phase_d   = phase_c;
    rr_d      = rr_c;
    pos_d     = pos_c;
    plane_d   = plane_c;
    fin_d     = fin_c;
    has_run_o = 1'b0;

    run_o.value       = b;
    run_o.pixel_index = pos_c[bprle_pkg::IDX_W-1:0];
    run_o.run_length  = len;
    run_o.plane       = plane_c;
    run_o.overrun     = cut;
    run_o.record_done = 1'b0;

    if (!fin_c) begin
      unique case (phase_c)
        bprle_pkg::PH_COUNT: begin
          if (!b[7]) begin
            rr_d    = b + 8'd1;
            phase_d = bprle_pkg::PH_REPEAT;
          end else begin
            rr_d    = 8'(9'h100 - {1'b0, b});
            phase_d = bprle_pkg::PH_LITERAL;
          end
        end
        bprle_pkg::PH_SKIP: begin
          rr_d = rr_c - bprle_pkg::LEN_W'(1);
          if (rr_d == '0) phase_d = bprle_pkg::PH_COUNT;
        end
        bprle_pkg::PH_REPEAT, bprle_pkg::PH_LITERAL: begin
          has_run_o = 1'b1;
          pos_d = pos_c + bprle_pkg::PIX_W'(len);
          if (plane_end) begin
            if (last_plane) begin
              fin_d             = 1'b1;
              run_o.record_done = 1'b1;
            end else begin
              plane_d = plane_c + bprle_pkg::PLANE_W'(1);
              pos_d   = '0;
            end
          end
          if (phase_c == bprle_pkg::PH_REPEAT || fin_d) begin
            rr_d    = '0;
            phase_d = bprle_pkg::PH_COUNT;
          end else begin
            rr_d = more;
            if (more == '0) phase_d = bprle_pkg::PH_COUNT;
            else if (plane_end) phase_d = bprle_pkg::PH_SKIP;
            else phase_d = bprle_pkg::PH_LITERAL;
          end
        end
        default: phase_d = bprle_pkg::PH_COUNT;
      endcase
    end
  end

endmodule

// ===== hw/rtl/byte_plane_rle_decoder_core.sv =====
// Top level of the byte plane RLE decoder: config registers, parser, placement stage.
//
//   channel   handshake               payload
//   in        in_valid_i/in_ready_o   in_item_i  (data_byte, start_record)
//   out       out_valid_o/out_ready_i out_item_o (run with lane and buffer offset)
//   cfg       cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One compressed byte per cycle while in_ready_o is high. A run item passes the s1 register, then the output register.
// Count and skipped bytes make no item. The stride multiply sits in the second stage.
// A stalled output holds its item; the first stage keeps taking bytes until it fills.
// Reset returns the parser to the start of a record and all config registers to 1.
module byte_plane_rle_decoder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bprle_pkg::in_item_t                 in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output bprle_pkg::out_item_t                out_item_o,
  input  logic                                cfg_we_i,
  input  logic [bprle_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bprle_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  bprle_pkg::cfg_t      cfg_q;
  bprle_pkg::run_t      run_c;
  bprle_pkg::run_t      s1_q;
  logic                 s1_valid_q;
  logic                 has_run;
  logic                 accept;
  logic                 out_adv;
  bprle_pkg::out_item_t out_d;
  bprle_pkg::out_item_t out_q;
  logic                 out_valid_q;

  logic [bprle_pkg::SB_W-1:0]     sb;
  logic [bprle_pkg::CH_W-1:0]     ch;
  logic [bprle_pkg::STRIDE_W-1:0] stride;
  logic [bprle_pkg::LANE_W-1:0]   lane;
  logic [bprle_pkg::OFF_W:0]      prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_count        <= bprle_pkg::PIX_W'(1);
      cfg_q.channel_count      <= bprle_pkg::CH_W'(1);
      cfg_q.sample_bytes       <= bprle_pkg::SB_W'(1);
      cfg_q.host_little_endian <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bprle_pkg::CFG_PIXEL_COUNT:
          cfg_q.pixel_count <= cfg_wdata_i[bprle_pkg::PIX_W-1:0];
        bprle_pkg::CFG_CHANNEL_COUNT:
          cfg_q.channel_count <= cfg_wdata_i[bprle_pkg::CH_W-1:0];
        bprle_pkg::CFG_SAMPLE_BYTES:
          cfg_q.sample_bytes <= cfg_wdata_i[bprle_pkg::SB_W-1:0];
        bprle_pkg::CFG_HOST_LE:
          cfg_q.host_little_endian <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign out_adv    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || out_adv;
  assign accept     = in_valid_i && in_ready_o;

  bprle_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_item_i),
    .cfg_i     (cfg_q),
    .has_run_o (has_run),
    .run_o     (run_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= has_run;
    end else if (out_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= run_c;
    end
  end

  // placement: lane by byte order, offset = lane + pixel * channels * bytes
  always_comb begin
    sb     = bprle_pkg::eff_bytes(cfg_q.sample_bytes);
    ch     = bprle_pkg::eff_channels(cfg_q.channel_count);
    stride = bprle_pkg::STRIDE_W'(ch) * bprle_pkg::STRIDE_W'(sb);
    lane   = bprle_pkg::lane_of(s1_q.plane, sb, cfg_q.host_little_endian);
    prod   = (bprle_pkg::OFF_W+1)'(s1_q.pixel_index) * (bprle_pkg::OFF_W+1)'(stride)
             + (bprle_pkg::OFF_W+1)'(lane);
    out_d.value       = s1_q.value;
    out_d.pixel_index = s1_q.pixel_index;
    out_d.run_length  = s1_q.run_length;
    out_d.byte_lane   = lane;
    out_d.byte_offset = prod[bprle_pkg::OFF_W-1:0];
    out_d.overrun     = s1_q.overrun;
    out_d.record_done = s1_q.record_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.run_length != 8'd0 && out_item_o.run_length <= 8'd128))
    else $error("run length out of range");

  a_run_in_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((15'(out_item_o.pixel_index) + 15'(out_item_o.run_length))
                     <= 15'(bprle_pkg::MAX_PIXELS)))
    else $error("run passes the largest plane");

  a_start_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_item_i.start_record) |=> !s1_valid_q)
    else $error("record start byte produced a run");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for byte_plane_rle_decoder_core: directed and random scanline records.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                                  clk_i = 1'b0;
  logic                                  rst_ni = 1'b0;
  logic                                  in_valid_i = 1'b0;
  logic                                  in_ready_o;
  bprle_pkg::in_item_t                   in_item_i = '0;
  logic                                  out_valid_o;
  logic                                  out_ready_i = 1'b0;
  bprle_pkg::out_item_t                  out_item_o;
  logic                                  cfg_we_i = 1'b0;
  logic [bprle_pkg::CFG_IDX_W-1:0]       cfg_idx_i = bprle_pkg::CFG_PIXEL_COUNT;
  logic [bprle_pkg::CFG_DATA_W-1:0]      cfg_wdata_i = '0;

  byte_plane_rle_decoder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // register shadow
  logic [bprle_pkg::PIX_W-1:0] cfg_pixels = bprle_pkg::PIX_W'(1);
  logic [bprle_pkg::CH_W-1:0]  cfg_channels = bprle_pkg::CH_W'(1);
  logic [bprle_pkg::SB_W-1:0]  cfg_bytes = bprle_pkg::SB_W'(1);
  logic                        cfg_le = 1'b1;

  // decoder state
  bprle_pkg::phase_e           dec_phase = bprle_pkg::PH_COUNT;
  int unsigned                 run_left = 0;
  logic [bprle_pkg::PIX_W-1:0] pix_pos = '0;
  int unsigned                 plane_no = 0;
  bit                          rec_finished = 1'b0;

  bprle_pkg::out_item_t pending_runs[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  bit          gaps_on = 1'b1;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned rec_budget = 0;
  bit          rec_first = 1'b0;

  function automatic int unsigned plane_pixels();
    if (cfg_pixels == '0) return 1;
    if (cfg_pixels > bprle_pkg::MAX_PIXELS) return bprle_pkg::MAX_PIXELS;
    return cfg_pixels;
  endfunction

  function automatic int unsigned record_planes();
    if (cfg_bytes == '0) return 1;
    if (cfg_bytes > bprle_pkg::MAX_BYTES) return bprle_pkg::MAX_BYTES;
    return cfg_bytes;
  endfunction

  // Advance the decoder by one compressed byte; returns 1 when a run comes out.
  function automatic bit decode_byte(input bprle_pkg::in_item_t it,
                                     output bprle_pkg::out_item_t run);
    int unsigned pc, sb, ch, want, more, pos, len, pl, lane, p;
    bit cut, at_end, done;
    run = '0;
    done = 1'b0;
    if (it.start_record) begin
      dec_phase = bprle_pkg::PH_COUNT;
      run_left = 0;
      pix_pos = '0;
      plane_no = 0;
      rec_finished = 1'b0;
    end
    if (rec_finished) return 1'b0;
    if (dec_phase == bprle_pkg::PH_COUNT) begin
      if (it.data_byte < 8'd128) begin
        run_left = it.data_byte + 1;
        dec_phase = bprle_pkg::PH_REPEAT;
      end else begin
        run_left = 256 - it.data_byte;
        dec_phase = bprle_pkg::PH_LITERAL;
      end
      return 1'b0;
    end
    if (dec_phase == bprle_pkg::PH_SKIP) begin
      run_left = (run_left - 1) & 8'hFF;
      if (run_left == 0) dec_phase = bprle_pkg::PH_COUNT;
      return 1'b0;
    end

    want = (dec_phase == bprle_pkg::PH_REPEAT) ? run_left : 1;
    if (want < 1) want = 1;
    more = (dec_phase == bprle_pkg::PH_LITERAL && run_left > 1) ? run_left - 1 : 0;
    pc = plane_pixels();
    sb = record_planes();
    pos = pix_pos;
    pl = plane_no;
    if (pos >= pc) begin
      len = 1;
      cut = 1'b1;
      at_end = 1'b1;
    end else begin
      cut = want > pc - pos;
      len = cut ? pc - pos : want;
      at_end = (pos + len == pc);
      if (at_end && more > 0) cut = 1'b1;
    end

    pix_pos = bprle_pkg::PIX_W'(pos + len);
    if (at_end) begin
      if (pl + 1 >= sb) begin
        rec_finished = 1'b1;
        done = 1'b1;
      end else begin
        plane_no = (pl + 1) & 3;
        pix_pos = '0;
      end
    end
    if (dec_phase == bprle_pkg::PH_REPEAT || rec_finished) begin
      run_left = 0;
      dec_phase = bprle_pkg::PH_COUNT;
    end else begin
      run_left = more;
      if (more == 0) dec_phase = bprle_pkg::PH_COUNT;
      else if (at_end) dec_phase = bprle_pkg::PH_SKIP;
      else dec_phase = bprle_pkg::PH_LITERAL;
    end

    if (cfg_channels == '0) ch = 1;
    else if (cfg_channels > bprle_pkg::MAX_CHANNELS) ch = bprle_pkg::MAX_CHANNELS;
    else ch = cfg_channels;
    p = (pl > sb - 1) ? sb - 1 : pl;
    lane = cfg_le ? sb - 1 - p : p;
    run.value = it.data_byte;
    run.pixel_index = bprle_pkg::IDX_W'(pos);
    run.run_length = bprle_pkg::LEN_W'(len);
    run.byte_lane = bprle_pkg::LANE_W'(lane);
    run.byte_offset = bprle_pkg::OFF_W'(lane + (pos & 32'h3FFF) * ch * sb);
    run.overrun = cut;
    run.record_done = done;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // output side: random stalls plus the long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    bprle_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_runs.size() == 0) begin
        report_mismatch("run item with nothing expected");
      end else begin
        want = pending_runs.pop_front();
        check_field("value", out_item_o.value, want.value);
        check_field("pixel_index", out_item_o.pixel_index, want.pixel_index);
        check_field("run_length", out_item_o.run_length, want.run_length);
        check_field("byte_lane", out_item_o.byte_lane, want.byte_lane);
        check_field("byte_offset", out_item_o.byte_offset, want.byte_offset);
        check_field("overrun", out_item_o.overrun, want.overrun);
        check_field("record_done", out_item_o.record_done, want.record_done);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic st);
    int gap;
    bprle_pkg::out_item_t run;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_item_i.data_byte = b;
    in_item_i.start_record = st;
    do @(posedge clk_i); while (!in_ready_o);
    if (decode_byte(in_item_i, run)) pending_runs.push_back(run);
    bytes_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bprle_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bprle_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    case (idx)
      bprle_pkg::CFG_PIXEL_COUNT:   cfg_pixels = val[bprle_pkg::PIX_W-1:0];
      bprle_pkg::CFG_CHANNEL_COUNT: cfg_channels = val[bprle_pkg::CH_W-1:0];
      bprle_pkg::CFG_SAMPLE_BYTES:  cfg_bytes = val[bprle_pkg::SB_W-1:0];
      bprle_pkg::CFG_HOST_LE:       cfg_le = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(input int unsigned pc, input int unsigned ch, input int unsigned sb,
                           input bit le);
    write_reg(bprle_pkg::CFG_PIXEL_COUNT, bprle_pkg::CFG_DATA_W'(pc));
    write_reg(bprle_pkg::CFG_CHANNEL_COUNT, bprle_pkg::CFG_DATA_W'(ch));
    write_reg(bprle_pkg::CFG_SAMPLE_BYTES, bprle_pkg::CFG_DATA_W'(sb));
    write_reg(bprle_pkg::CFG_HOST_LE, bprle_pkg::CFG_DATA_W'(le));
  endtask

  function automatic int unsigned pick_run(input int unsigned left);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(1, 128);
    if (r == 1 && left < 124) return left + $urandom_range(1, 4);
    return $urandom_range(1, (left < 128) ? left : 128);
  endfunction

  task automatic put_rec_byte(input logic [7:0] b);
    if (rec_budget != 0) begin
      send_item(b, rec_first);
      rec_first = 1'b0;
      rec_budget--;
    end
  endtask

  // Record for the current settings, with some runs that may overrun the plane; a small budget cuts it short.
  task automatic send_record(input int unsigned budget);
    int unsigned left, n;
    rec_budget = budget;
    rec_first = 1'b1;
    repeat (record_planes()) begin
      left = plane_pixels();
      while (left != 0) begin
        n = pick_run(left);
        if ($urandom_range(0, 1)) begin
          put_rec_byte(8'(n - 1));
          put_rec_byte(8'($urandom));
        end else begin
          put_rec_byte(8'(256 - n));
          repeat (n) put_rec_byte(8'($urandom));
        end
        left -= (n < left) ? n : left;
      end
    end
    repeat ($urandom_range(0, 2)) put_rec_byte(8'($urandom));
  endtask

  task automatic test_after_reset();
    send_item(8'h00, 1'b0);
    send_item(8'hA5, 1'b0);
    send_item(8'h3C, 1'b0);  // record finished: ignored
  endtask

  task automatic test_runs_and_literals();
    settle();
    configure(4, 3, 2, 1'b0);
    send_item(8'h01, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFE, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b0);  // repeat cut at plane end
    send_item(8'h55, 1'b0);
    send_item(8'h12, 1'b0);
  endtask

  task automatic test_literal_overrun();
    settle();
    configure(2, 0, 2, 1'b1);
    send_item(8'hFC, 1'b1);
    send_item(8'h11, 1'b0);
    send_item(8'h22, 1'b0);
    send_item(8'h33, 1'b0);  // skipped
    send_item(8'h44, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h66, 1'b0);
  endtask

  task automatic test_config_mid_record();
    settle();
    configure(8, 5, 1, 1'b0);
    send_item(8'h03, 1'b1);
    send_item(8'h11, 1'b0);
    settle();
    write_reg(bprle_pkg::CFG_PIXEL_COUNT, bprle_pkg::CFG_DATA_W'(2));
    send_item(8'h00, 1'b0);
    send_item(8'h22, 1'b0);
    settle();
    write_reg(bprle_pkg::CFG_SAMPLE_BYTES, bprle_pkg::CFG_DATA_W'(3));
    send_item(8'h01, 1'b1);
    send_item(8'hAA, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'hBB, 1'b0);
    settle();
    configure(2, 16, 2, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hCC, 1'b0);
  endtask

  task automatic test_largest_plane();
    settle();
    configure(15'h7FFF, 31, 7, 1'($urandom));
    send_item(8'h7F, 1'b1);
    send_item(8'($urandom), 1'b0);
    repeat (126) begin
      send_item(8'h7F, 1'b0);
      send_item(8'($urandom), 1'b0);
    end
    send_item(8'h7E, 1'b0);
    send_item(8'($urandom), 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'($urandom), 1'b0);
  endtask

  task automatic test_output_backpressure();
    settle();
    configure(200, 1, 1, 1'b0);
    gaps_on = 1'b0;
    hold_left = 80;
    send_item(8'h00, 1'b1);
    send_item(8'($urandom), 1'b0);
    repeat (60) begin
      send_item(8'h00, 1'b0);
      send_item(8'($urandom), 1'b0);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_records();
    int unsigned goal;
    int r;
    goal = bytes_sent + 300;
    while (bytes_sent < goal) begin
      settle();
      configure(($urandom_range(0, 9) < 8) ? $urandom_range(0, 24) : $urandom_range(25, 80),
                $urandom_range(0, 31), $urandom_range(0, 7), 1'($urandom));
      gaps_on = ($urandom_range(0, 4) != 0);
      repeat ($urandom_range(2, 6)) begin
        if (bytes_sent < goal) begin
          r = $urandom_range(0, 9);
          if (r < 7) begin
            send_record(goal + 40 - bytes_sent);
          end else if (r < 9) begin
            send_record($urandom_range(1, 12));
          end else begin
            repeat ($urandom_range(1, 10))
              send_item(8'($urandom), $urandom_range(0, 5) == 0);
          end
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_after_reset();
    test_runs_and_literals();
    test_literal_overrun();
    test_config_mid_record();
    test_largest_plane();
    test_output_backpressure();
    test_random_records();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d runs outstanding", pending_runs.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== byte_plane_rle_decoder_core.f =====
hw/rtl/bprle_pkg.sv
hw/rtl/bprle_parse.sv
hw/rtl/byte_plane_rle_decoder_core.sv
tb/tb_top.sv
